// File: rtl/tfbb_pkg.sv
// ---------------------------------------------------------------------------
// tfbb_pkg
// Shared types and constants of the transformed frame bounding box block.
// ---------------------------------------------------------------------------
`default_nettype none

package tfbb_pkg;

	// field widths
	localparam int RotW     = 24;
	localparam int ShiftW   = 32;
	localparam int ExtW     = 12;
	localparam int VpmW     = 24;
	localparam int ProdW    = 37;
	localparam int BoxW     = 40;
	localparam int SizeW    = 16;
	localparam int CountW   = 24;
	localparam int DiffLoW  = 20;
	localparam int PartW    = 44;
	localparam int FullW    = 64;

	// stream and config port widths
	localparam int InDataW  = 240;
	localparam int OutDataW = 192;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	// frame queue geometry
	localparam int QDepth   = 4;
	localparam int QPtrW    = 2;
	localparam int QCntW    = 3;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_MIN_COL = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_COL = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_ROW = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_ROW = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_VPM     = 3'd4;

	typedef logic signed [RotW-1:0]   rot_t;
	typedef logic signed [ShiftW-1:0] shift_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [BoxW-1:0]   box_t;
	typedef logic [BoxW-1:0]          diff_t;
	typedef logic [PartW-1:0]         part_t;
	typedef logic [CountW-1:0]        count_t;
	typedef logic [SizeW-1:0]         size_t;

	localparam box_t   BOX_POS_MAX = {1'b0, {(BoxW-1){1'b1}}};
	localparam box_t   BOX_NEG_MIN = {1'b1, {(BoxW-1){1'b0}}};
	localparam count_t COUNT_MAX   = '1;
	localparam size_t  SIZE_MAX    = '1;

	// configuration registers
	typedef struct packed {
		logic [ExtW-1:0] min_col;
		logic [ExtW-1:0] max_col;
		logic [ExtW-1:0] min_row;
		logic [ExtW-1:0] max_row;
		logic [VpmW-1:0] vpm;
	} cfg_t;

	// one frame's affine pose
	typedef struct packed {
		rot_t   xx;
		rot_t   xy;
		shift_t tx;
		rot_t   yx;
		rot_t   yy;
		shift_t ty;
		rot_t   zx;
		rot_t   zy;
		shift_t tz;
	} pose_t;

	// per-frame box handed from front to back, index 0 is x
	typedef struct packed {
		logic [2:0][BoxW-1:0] lo;
		logic [2:0][BoxW-1:0] hi;
		logic                 pose_valid;
		logic                 seq_end;
	} frame_box_t;

	// one result word
	typedef struct packed {
		logic [CountW-1:0] frames_used;
		logic [BoxW-1:0]   corner_z;
		logic [BoxW-1:0]   corner_y;
		logic [BoxW-1:0]   corner_x;
		logic [SizeW-1:0]  size_z;
		logic [SizeW-1:0]  size_y;
		logic [SizeW-1:0]  size_x;
		logic              no_valid;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/tfbb_front.sv
// ---------------------------------------------------------------------------
// tfbb_front
// Transform pipeline: maps the image extents through the pose and reduces
// the four corners to a per-frame min/max box on each axis.
// ---------------------------------------------------------------------------
`default_nettype none

module tfbb_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  tfbb_pkg::pose_t      pose,
	input  wire                  pose_valid,
	input  wire                  seq_end,
	input  tfbb_pkg::cfg_t       cfg,
	output logic                 out_valid,
	input  wire                  out_ready,
	output tfbb_pkg::frame_box_t out_box
);

	logic en;

	tfbb_pkg::rot_t   rot_c [3];
	tfbb_pkg::rot_t   rot_r [3];
	tfbb_pkg::shift_t shift [3];
	logic signed [tfbb_pkg::ExtW:0] col_lo, col_hi, row_lo, row_hi;

	// stage 1: products
	logic             v_s1, pv_s1, end_s1;
	tfbb_pkg::prod_t  pcl_s1 [3];
	tfbb_pkg::prod_t  pch_s1 [3];
	tfbb_pkg::prod_t  prl_s1 [3];
	tfbb_pkg::prod_t  prh_s1 [3];
	tfbb_pkg::shift_t t_s1   [3];

	// stage 2: per-term extremes
	logic             v_s2, pv_s2, end_s2;
	tfbb_pkg::prod_t  cmin_s2 [3];
	tfbb_pkg::prod_t  cmax_s2 [3];
	tfbb_pkg::prod_t  rmin_s2 [3];
	tfbb_pkg::prod_t  rmax_s2 [3];
	tfbb_pkg::shift_t t_s2    [3];

	// stage 3: corner box
	logic             v_s3, pv_s3, end_s3;
	tfbb_pkg::box_t   lo_s3 [3];
	tfbb_pkg::box_t   hi_s3 [3];

	// the whole pipe moves unless the last stage is blocked by the queue
	assign en       = !v_s3 || out_ready;
	assign in_ready = en;

	// pose terms by axis, extents as signed operands
	always_comb begin
		rot_c[0] = pose.xx;  rot_r[0] = pose.xy;  shift[0] = pose.tx;
		rot_c[1] = pose.yx;  rot_r[1] = pose.yy;  shift[1] = pose.ty;
		rot_c[2] = pose.zx;  rot_r[2] = pose.zy;  shift[2] = pose.tz;
		col_lo = $signed({1'b0, cfg.min_col});
		col_hi = $signed({1'b0, cfg.max_col});
		row_lo = $signed({1'b0, cfg.min_row});
		row_hi = $signed({1'b0, cfg.max_row});
	end

	// valid flags; words with neither a pose nor an end mark are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && (pose_valid || seq_end);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			pv_s1  <= pose_valid;
			end_s1 <= seq_end;
			pv_s2  <= pv_s1;
			end_s2 <= end_s1;
			pv_s3  <= pv_s2;
			end_s3 <= end_s2;
			for (int a = 0; a < 3; a++) begin
				pcl_s1[a] <= tfbb_pkg::prod_t'(rot_c[a] * col_lo);
				pch_s1[a] <= tfbb_pkg::prod_t'(rot_c[a] * col_hi);
				prl_s1[a] <= tfbb_pkg::prod_t'(rot_r[a] * row_lo);
				prh_s1[a] <= tfbb_pkg::prod_t'(rot_r[a] * row_hi);
				t_s1[a]   <= shift[a];

				// the corner set is separable: extremes per term
				cmin_s2[a] <= (pcl_s1[a] < pch_s1[a]) ? pcl_s1[a] : pch_s1[a];
				cmax_s2[a] <= (pcl_s1[a] < pch_s1[a]) ? pch_s1[a] : pcl_s1[a];
				rmin_s2[a] <= (prl_s1[a] < prh_s1[a]) ? prl_s1[a] : prh_s1[a];
				rmax_s2[a] <= (prl_s1[a] < prh_s1[a]) ? prh_s1[a] : prl_s1[a];
				t_s2[a]    <= t_s1[a];

				lo_s3[a] <= tfbb_pkg::box_t'(cmin_s2[a]) + tfbb_pkg::box_t'(rmin_s2[a])
					+ tfbb_pkg::box_t'(t_s2[a]);
				hi_s3[a] <= tfbb_pkg::box_t'(cmax_s2[a]) + tfbb_pkg::box_t'(rmax_s2[a])
					+ tfbb_pkg::box_t'(t_s2[a]);
			end
		end
	end

	// queue word
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			out_box.lo[a] = lo_s3[a];
			out_box.hi[a] = hi_s3[a];
		end
		out_box.pose_valid = pv_s3;
		out_box.seq_end    = end_s3;
	end
	assign out_valid = v_s3;

endmodule

`default_nettype wire

// File: rtl/tfbb_fifo.sv
// ---------------------------------------------------------------------------
// tfbb_fifo
// Short register queue of per-frame boxes between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module tfbb_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  tfbb_pkg::frame_box_t push_data,
	input  wire                  pop,
	output tfbb_pkg::frame_box_t head,
	output logic                 full,
	output logic                 empty
);

	tfbb_pkg::frame_box_t           mem_q [tfbb_pkg::QDepth];
	logic [tfbb_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [tfbb_pkg::QCntW-1:0]     cnt_q;

	assign full  = cnt_q == tfbb_pkg::QCntW'(tfbb_pkg::QDepth);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// File: rtl/tfbb_back.sv
// ---------------------------------------------------------------------------
// tfbb_back
// Running box and frame count, and the result pipeline that turns the
// closed box into voxel sizes on an end mark.
// ---------------------------------------------------------------------------
`default_nettype none

module tfbb_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  tfbb_pkg::frame_box_t         head,
	output logic                         pop,
	input  wire [tfbb_pkg::VpmW-1:0]     vpm,
	output logic                         res_valid,
	input  wire                          res_ready,
	output tfbb_pkg::result_t            res
);

	logic en_r;

	// running box
	tfbb_pkg::box_t   lo_q [3];
	tfbb_pkg::box_t   hi_q [3];
	tfbb_pkg::count_t count_q;
	tfbb_pkg::box_t   nlo [3];
	tfbb_pkg::box_t   nhi [3];
	tfbb_pkg::count_t ncount;

	// stage 1: closed box
	logic             v_s1;
	tfbb_pkg::box_t   lo_s1 [3];
	tfbb_pkg::box_t   hi_s1 [3];
	tfbb_pkg::count_t cnt_s1;

	// stage 2: widths
	logic             v_s2, empty_s2;
	tfbb_pkg::diff_t  diff_s2 [3];
	tfbb_pkg::box_t   lo_s2   [3];
	tfbb_pkg::count_t cnt_s2;

	// stage 3: partial products
	logic             v_s3, empty_s3;
	tfbb_pkg::part_t  ph_s3 [3];
	tfbb_pkg::part_t  pl_s3 [3];
	tfbb_pkg::box_t   lo_s3 [3];
	tfbb_pkg::count_t cnt_s3;

	logic [tfbb_pkg::FullW-1:0] full_p [3];
	tfbb_pkg::size_t            size   [3];

	logic              res_valid_q;
	tfbb_pkg::result_t res_q;

	// result chain moves as one while the output word is free
	assign en_r = !res_valid_q || res_ready;
	assign pop  = in_valid && (!head.seq_end || en_r);

	// box widened by the head word
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nlo[a] = lo_q[a];
			nhi[a] = hi_q[a];
			if (head.pose_valid && ($signed(head.lo[a]) < lo_q[a])) nlo[a] = head.lo[a];
			if (head.pose_valid && ($signed(head.hi[a]) > hi_q[a])) nhi[a] = head.hi[a];
		end
		ncount = count_q;
		if (head.pose_valid && (count_q != tfbb_pkg::COUNT_MAX)) ncount = count_q + 1'b1;
	end

	// running box, cleared after an end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= tfbb_pkg::BOX_POS_MAX;
				hi_q[a] <= tfbb_pkg::BOX_NEG_MIN;
			end
			count_q <= '0;
		end else if (pop) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= head.seq_end ? tfbb_pkg::BOX_POS_MAX : nlo[a];
				hi_q[a] <= head.seq_end ? tfbb_pkg::BOX_NEG_MIN : nhi[a];
			end
			count_q <= head.seq_end ? '0 : ncount;
		end
	end

	// result valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en_r) begin
			v_s1        <= pop && head.seq_end;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	// final product assembly and saturation
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			full_p[a] = {ph_s3[a], {tfbb_pkg::DiffLoW{1'b0}}}
				+ {{tfbb_pkg::DiffLoW{1'b0}}, pl_s3[a]};
			size[a] = (|full_p[a][63:48]) ? tfbb_pkg::SIZE_MAX : full_p[a][47:32];
		end
	end

	// result datapath
	always_ff @(posedge clk) begin
		if (en_r) begin
			for (int a = 0; a < 3; a++) begin
				lo_s1[a] <= nlo[a];
				hi_s1[a] <= nhi[a];

				diff_s2[a] <= (hi_s1[a] >= lo_s1[a]) ?
					tfbb_pkg::diff_t'(hi_s1[a] - lo_s1[a]) : '0;
				lo_s2[a] <= lo_s1[a];

				// width times voxel density, split at bit 20
				ph_s3[a] <= tfbb_pkg::part_t'(diff_s2[a][39:20] * vpm);
				pl_s3[a] <= tfbb_pkg::part_t'(diff_s2[a][19:0] * vpm);
				lo_s3[a] <= lo_s2[a];
			end
			cnt_s1   <= ncount;
			cnt_s2   <= cnt_s1;
			empty_s2 <= cnt_s1 == '0;
			cnt_s3   <= cnt_s2;
			empty_s3 <= empty_s2;

			// an empty sequence reports zeros and the flag
			if (empty_s3) begin
				res_q.size_x      <= '0;
				res_q.size_y      <= '0;
				res_q.size_z      <= '0;
				res_q.corner_x    <= '0;
				res_q.corner_y    <= '0;
				res_q.corner_z    <= '0;
				res_q.frames_used <= '0;
				res_q.no_valid    <= 1'b1;
			end else begin
				res_q.size_x      <= size[0];
				res_q.size_y      <= size[1];
				res_q.size_z      <= size[2];
				res_q.corner_x    <= lo_s3[0];
				res_q.corner_y    <= lo_s3[1];
				res_q.corner_z    <= lo_s3[2];
				res_q.frames_used <= cnt_s3;
				res_q.no_valid    <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: rtl/transformed_frame_bounding_box.sv
// ---------------------------------------------------------------------------
// transformed_frame_bounding_box
// Axis-aligned box of image frames mapped through per-frame affine poses.
// ---------------------------------------------------------------------------
// Takes one pose word per clock while s_tready is high; the full queue can
// hold the front. A three-stage transform pipeline maps the configured image
// extents through each valid pose to a per-frame box, a four-entry queue
// passes it to the accumulator, and on the word with tlast a four-stage
// result pipeline turns the running box into voxel sizes. A stalled result
// output holds the result pipeline, but the accumulator and front keep
// taking frames until a word with tlast reaches the head of the queue and
// the queue fills behind it. The user must write configuration only while
// the block is idle; the block does not enforce it. Rotation Q7.16,
// translation Q15.16, box corners Q23.16, voxels per mm unsigned Q8.16.
`default_nettype none

module transformed_frame_bounding_box (
	input  wire                              clk,
	input  wire                              arst_n,
	// config write port
	input  wire                              cfg_we,
	input  wire [tfbb_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire [tfbb_pkg::CfgDataW-1:0]     cfg_data,
	// pose stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// rot_xx, rot_xy, shift_x, rot_yx, rot_yy, shift_y, rot_zx, rot_zy, shift_z
	input  wire [tfbb_pkg::InDataW-1:0]      s_tdata,
	// pose_valid
	input  wire                              s_tuser,
	// seq_end
	input  wire                              s_tlast,
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// size_x, size_y, size_z, corner_x, corner_y, corner_z, frames_used
	output logic [tfbb_pkg::OutDataW-1:0]    m_tdata,
	// no_valid_frames
	output logic                             m_tuser
);

	tfbb_pkg::cfg_t       cfg_q;
	tfbb_pkg::pose_t      pose;
	tfbb_pkg::frame_box_t q_in, q_head;
	tfbb_pkg::result_t    res;
	logic                 q_push, q_pop, q_full, q_empty, front_valid;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_col <= 12'd0;
			cfg_q.max_col <= 12'd819;
			cfg_q.min_row <= 12'd0;
			cfg_q.max_row <= 12'd615;
			cfg_q.vpm     <= 24'd131072;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfbb_pkg::REG_MIN_COL: cfg_q.min_col <= cfg_data[11:0];
				tfbb_pkg::REG_MAX_COL: cfg_q.max_col <= cfg_data[11:0];
				tfbb_pkg::REG_MIN_ROW: cfg_q.min_row <= cfg_data[11:0];
				tfbb_pkg::REG_MAX_ROW: cfg_q.max_row <= cfg_data[11:0];
				tfbb_pkg::REG_VPM:     cfg_q.vpm     <= cfg_data;
				default:               cfg_q         <= cfg_q;
			endcase
		end
	end

	// unpack the pose word
	always_comb begin
		pose.xx = s_tdata[23:0];
		pose.xy = s_tdata[47:24];
		pose.tx = s_tdata[79:48];
		pose.yx = s_tdata[103:80];
		pose.yy = s_tdata[127:104];
		pose.ty = s_tdata[159:128];
		pose.zx = s_tdata[183:160];
		pose.zy = s_tdata[207:184];
		pose.tz = s_tdata[239:208];
	end

	tfbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.pose       (pose),
		.pose_valid (s_tuser),
		.seq_end    (s_tlast),
		.cfg        (cfg_q),
		.out_valid  (front_valid),
		.out_ready  (!q_full),
		.out_box    (q_in)
	);

	assign q_push = front_valid && !q_full;

	tfbb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tfbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.vpm       (cfg_q.vpm),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result word
	assign m_tdata = {res.frames_used, res.corner_z, res.corner_y, res.corner_x,
		res.size_z, res.size_y, res.size_x};
	assign m_tuser = res.no_valid;

	// queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("frame queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("frame queue popped while empty");

	// an empty sequence carries an all-zero word
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0)) else $error("empty result not zero");

	// a non-empty result counts at least one frame
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[191:168] != '0))
		else $error("result without frames not flagged");

endmodule

`default_nettype wire
